// ===== design/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// shared types and constants for the scanline span filler
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int MaxVertices = 16;
  localparam int CoordBits   = 12;
  localparam int IdxBits     = $clog2(MaxVertices);
  localparam int CntBits     = IdxBits + 1;
  localparam int DivBits     = 2 * CoordBits + 2;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_RENDER = 2'd2;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [IdxBits-1:0]   idx_t;
  typedef logic [CntBits-1:0]   cnt_t;

  // controller to datapath
  typedef struct packed {
    logic capture;      // latch input item
    logic clear;        // empty vertex list
    logic append;       // store vertex
    logic rd_edge;      // read edge i (memory read)
    logic edge_setup;   // register edge endpoints, test crossing
    logic div_start;    // start divider for current edge
    logic div_step;     // one divider step
    logic store_cross;  // store crossing, advance k
    logic sort_load;    // load crossing pair for compare
    logic sort_swap;    // write back pair in order
    logic out_load;     // load output pair
    idx_t edge_idx;
    idx_t sort_idx;
    idx_t pair_idx;
  } spf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    cnt_t       vcount;
    cnt_t       kcount;
    logic       crosses;
    logic       swapped;   // earlier compare of this sort pass changed something
    logic       swap_now;  // loaded pair is out of order
  } spf_sts_t;

endpackage

// ===== design/spf_datapath.sv =====
// ----------------------------------------------------------------------------
// spf_datapath
// vertex store, restoring divider, crossing list and bubble sorter
// ----------------------------------------------------------------------------
module spf_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  spf_pkg::spf_cmd_t cmd,
  output spf_pkg::spf_sts_t sts,
  input  logic [1:0]       in_command,
  input  spf_pkg::coord_t  in_x,
  input  spf_pkg::coord_t  in_y,
  input  logic             sort_clr,
  output spf_pkg::coord_t  o_row,
  output spf_pkg::coord_t  o_start,
  output logic [spf_pkg::CoordBits:0] o_end,
  output logic             o_last
);
  import spf_pkg::*;

  coord_t vx_mem [MaxVertices];
  coord_t vy_mem [MaxVertices];
  coord_t cl_r   [MaxVertices];

  logic [1:0] cmd_r;
  coord_t cx_r, cy_r;
  cnt_t vcount_r, kcount_r;
  coord_t ax_r, ay_r, bx_r, by_r;
  coord_t ra_x_r;
  logic crosses_r, swapped_r;

  // divider state: |num| / |dy|
  logic [DivBits-1:0] num_r, quo_r;
  logic [CoordBits-1:0] den_r;
  logic [CoordBits:0] rem_r;
  logic neg_r;

  coord_t s0_r, s1_r;

  idx_t nx;
  logic signed [CoordBits:0] dx, dy, dr;
  logic signed [2*CoordBits+1:0] prod;
  logic [CoordBits+1:0] rtry;
  logic [CoordBits:0] rsh;
  logic signed [DivBits+1:0] qs, res;

  always_comb begin
    nx = (({1'b0, cmd.edge_idx} + 1'b1) < {1'b0, vcount_r}) ?
         idx_t'(cmd.edge_idx + 1'b1) : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.append && vcount_r < cnt_t'(MaxVertices)) begin
      vx_mem[vcount_r[IdxBits-1:0]] <= cx_r;
      vy_mem[vcount_r[IdxBits-1:0]] <= cy_r;
    end
    if (cmd.rd_edge) begin
      ax_r <= vx_mem[cmd.edge_idx];
      ay_r <= vy_mem[cmd.edge_idx];
      bx_r <= vx_mem[nx];
      by_r <= vy_mem[nx];
    end
  end

  always_comb begin
    dx   = $signed({1'b0, bx_r}) - $signed({1'b0, ax_r});
    dy   = $signed({1'b0, by_r}) - $signed({1'b0, ay_r});
    dr   = $signed({1'b0, cy_r}) - $signed({1'b0, ay_r});
    prod = dx * dr;
    rsh  = {rem_r[CoordBits-1:0], num_r[DivBits-1]};
    rtry = {1'b0, rsh} - {2'b0, den_r};
    // floor of a negative quotient: -q when exact, else -q - 1 (= ~q)
    qs   = neg_r ? ((rem_r != '0) ? ~$signed({2'b0, quo_r})
                                  : -$signed({2'b0, quo_r}))
                 : $signed({2'b0, quo_r});
    res  = qs + $signed({{(DivBits-CoordBits+2){1'b0}}, ra_x_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      kcount_r <= '0;
      swapped_r <= 1'b0;
    end else begin
      if (cmd.clear) vcount_r <= '0;
      if (cmd.append && vcount_r < cnt_t'(MaxVertices)) vcount_r <= vcount_r + 1'b1;
      if (cmd.capture) kcount_r <= '0;
      if (cmd.store_cross) kcount_r <= kcount_r + 1'b1;
      if (sort_clr) swapped_r <= 1'b0;
      else if (cmd.sort_swap && s0_r > s1_r) swapped_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_command;
      cx_r  <= in_x;
      cy_r  <= in_y;
    end
    if (cmd.edge_setup) begin
      crosses_r <= (ay_r <= cy_r && by_r > cy_r) || (ay_r > cy_r && by_r <= cy_r);
      ra_x_r <= ax_r;
      num_r  <= prod[DivBits-1:0];
      den_r  <= dy[CoordBits] ? coord_t'(-dy) : dy[CoordBits-1:0];
      neg_r  <= prod[2*CoordBits+1] ^ dy[CoordBits];
    end
    if (cmd.div_start) begin
      num_r  <= num_r[DivBits-1] ? DivBits'(-$signed(num_r)) : num_r;
      rem_r  <= '0;
      quo_r  <= '0;
    end
    if (cmd.div_step) begin
      if (!rtry[CoordBits+1]) begin
        rem_r <= rtry[CoordBits:0];
        quo_r <= {quo_r[DivBits-2:0], 1'b1};
      end else begin
        rem_r <= rsh;
        quo_r <= {quo_r[DivBits-2:0], 1'b0};
      end
      num_r  <= {num_r[DivBits-2:0], 1'b0};
    end
    if (cmd.store_cross)
      cl_r[kcount_r[IdxBits-1:0]] <= res[DivBits+1] ? '0 : res[CoordBits-1:0];
    if (cmd.sort_load) begin
      s0_r <= cl_r[cmd.sort_idx];
      s1_r <= cl_r[idx_t'(cmd.sort_idx + 1'b1)];
    end
    if (cmd.sort_swap && s0_r > s1_r) begin
      cl_r[cmd.sort_idx] <= s1_r;
      cl_r[idx_t'(cmd.sort_idx + 1'b1)] <= s0_r;
    end
    if (cmd.out_load) begin
      o_row   <= cy_r;
      o_start <= cl_r[idx_t'({cmd.pair_idx, 1'b0})];
      o_end   <= {1'b0, cl_r[idx_t'({cmd.pair_idx, 1'b1})]} + 1'b1;
      o_last  <= ({1'b0, cmd.pair_idx} + 1'b1) == {1'b0, kcount_r[CntBits-1:1]};
    end
  end

  assign sts.command  = cmd_r;
  assign sts.vcount   = vcount_r;
  assign sts.kcount   = kcount_r;
  assign sts.crosses  = crosses_r;
  assign sts.swapped  = swapped_r;
  assign sts.swap_now = s0_r > s1_r;

endmodule

// ===== design/spf_ctrl.sv =====
// ----------------------------------------------------------------------------
// spf_ctrl
// command sequencer: edge walk, divider steps, sort passes, span output
// ----------------------------------------------------------------------------
module spf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  spf_pkg::spf_sts_t sts,
  output spf_pkg::spf_cmd_t cmd,
  output logic              sort_clr
);
  import spf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_TEST  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_STORE = 4'd6;
  localparam logic [3:0] S_SLOAD = 4'd7;
  localparam logic [3:0] S_SSWAP = 4'd8;
  localparam logic [3:0] S_OLOAD = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r, state_nxt;
  idx_t ei_r, ei_nxt, si_r, si_nxt, pi_r, pi_nxt;
  logic [$clog2(DivBits+1)-1:0] dc_r, dc_nxt;
  logic last_edge, last_cmp;

  assign last_edge = ({1'b0, ei_r} + 1'b1) >= sts.vcount;
  assign last_cmp  = ({1'b0, si_r} + 2'd2) >= sts.kcount;

  always_comb begin
    state_nxt = state_r;
    ei_nxt = ei_r; si_nxt = si_r; pi_nxt = pi_r; dc_nxt = dc_r;
    cmd = '0;
    cmd.edge_idx = ei_r;
    cmd.sort_idx = si_r;
    cmd.pair_idx = pi_r;
    sort_clr = 1'b0;
    in_tready = (state_r == S_IDLE);
    out_tvalid = (state_r == S_OUT);
    case (state_r)
      S_IDLE: if (in_tvalid) begin
        cmd.capture = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        ei_nxt = '0;
        case (sts.command)
          CMD_CLEAR: begin cmd.clear = 1'b1; state_nxt = S_IDLE; end
          CMD_APPEND: begin cmd.append = 1'b1; state_nxt = S_IDLE; end
          CMD_RENDER: state_nxt = (sts.vcount != '0) ? S_RD : S_IDLE;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RD: begin cmd.rd_edge = 1'b1; state_nxt = S_SETUP; end
      S_SETUP: begin cmd.edge_setup = 1'b1; state_nxt = S_TEST; end
      S_TEST: begin
        if (sts.crosses) begin
          cmd.div_start = 1'b1;
          dc_nxt = '0;
          state_nxt = S_DIV;
        end else if (last_edge) begin
          si_nxt = '0; sort_clr = 1'b1;
          state_nxt = S_SLOAD;
        end else begin
          ei_nxt = idx_t'(ei_r + 1'b1);
          state_nxt = S_RD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dc_nxt = dc_r + 1'b1;
        if (dc_r == ($bits(dc_r))'(DivBits - 1)) state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.store_cross = 1'b1;
        if (last_edge) begin
          si_nxt = '0; sort_clr = 1'b1;
          state_nxt = S_SLOAD;
        end else begin
          ei_nxt = idx_t'(ei_r + 1'b1);
          state_nxt = S_RD;
        end
      end
      S_SLOAD: begin
        if (sts.kcount < cnt_t'(2)) state_nxt = S_IDLE;
        else begin cmd.sort_load = 1'b1; state_nxt = S_SSWAP; end
      end
      S_SSWAP: begin
        cmd.sort_swap = 1'b1;
        if (!last_cmp) begin
          si_nxt = idx_t'(si_r + 1'b1);
          state_nxt = S_SLOAD;
        end else begin
          si_nxt = '0;
          state_nxt = S_SLOAD;
          sort_clr = 1'b1;
          // the pass is clean only if the final compare keeps its pair too
          if (!sts.swapped && !sts.swap_now) begin
            pi_nxt = '0;
            state_nxt = S_OLOAD;
            sort_clr = 1'b0;
          end
        end
      end
      S_OLOAD: begin cmd.out_load = 1'b1; state_nxt = S_OUT; end
      S_OUT: if (out_tready) begin
        if (({1'b0, pi_r} + 1'b1) >= {1'b0, sts.kcount[CntBits-1:1]})
          state_nxt = S_IDLE;
        else begin
          pi_nxt = idx_t'(pi_r + 1'b1);
          state_nxt = S_OLOAD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ei_r <= '0; si_r <= '0; pi_r <= '0; dc_r <= '0;
    end else begin
      state_r <= state_nxt;
      ei_r <= ei_nxt; si_r <= si_nxt; pi_r <= pi_nxt; dc_r <= dc_nxt;
    end
  end

endmodule

// ===== design/scanline_polygon_span_fill_top.sv =====
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill_top
// polygon scanline filler with clear, append and render commands
// ----------------------------------------------------------------------------
// one command transaction at a time. clear and append are captured, then executed
// in the decode state. render walks the edges (read, setup and test states each,
// plus 26 bit-serial divider steps and a store step for every crossing edge),
// then bubble sorts the crossing list with a load and a swap state per compare
// until a pass makes no swap, and emits the spans one at a time, each loaded and
// then held while out_tready is low. the divider steps dominate a render
module scanline_polygon_span_fill_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // command[1:0], coord_x[13:2], coord_y[25:14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // row[11:0], span_start[23:12], span_end[36:24]
  output logic        out_tlast   // last span of the scanline
);
  import spf_pkg::*;

  spf_cmd_t cmd;
  spf_sts_t sts;
  logic sort_clr;
  coord_t o_row, o_start;
  logic [CoordBits:0] o_end;

  spf_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .sts, .cmd, .sort_clr
  );

  spf_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_command(in_tdata[1:0]),
    .in_x(in_tdata[13:2]),
    .in_y(in_tdata[25:14]),
    .sort_clr,
    .o_row, .o_start, .o_end, .o_last(out_tlast)
  );

  assign out_tdata = {3'b0, o_end, o_start, o_row};

endmodule
